// File: rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the table encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GTDE_ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
`define GTDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`else
`define GTDE_ASSERT_CLK(lbl, ck, rs, prop, msg)
`define GTDE_ASSERT(lbl, prop, msg)
`endif
`endif

// File: rtl/gtde_pkg.sv
// Types, constants and helpers of the greedy table encoder.
`default_nettype none
package gtde_pkg;

  localparam int TABLE_ENTRIES_DEF     = 64;
  localparam int MAX_KEY_BITS_DEF      = 16;
  localparam int MAX_VALUE_SYMBOLS_DEF = 16;
  localparam int SEGMENT_LENGTH_DEF    = 1024;

  localparam int KEY_W  = 16;
  localparam int LEN_W  = 5;
  localparam int VAL_W  = 32;
  localparam int WORK_W = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // GA GT CA CT, first nucleotide in the low bits
  localparam logic [VAL_W-1:0] PAIR_GA = 32'd2;
  localparam logic [VAL_W-1:0] PAIR_GT = 32'd14;
  localparam logic [VAL_W-1:0] PAIR_CA = 32'd1;
  localparam logic [VAL_W-1:0] PAIR_CT = 32'd13;
  localparam logic [LEN_W-1:0] PAIR_COUNT = 5'd2;

  typedef struct packed {
    logic             mode;
    logic [5:0]       entry_index;
    logic             entry_enable;
    logic [KEY_W-1:0] key_bits;
    logic [LEN_W-1:0] key_length;
    logic [VAL_W-1:0] value_symbols;
    logic [LEN_W-1:0] value_length;
    logic             data_bit;
    logic             stream_last;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] symbols;
    logic [LEN_W-1:0] symbol_count;
    logic             used_fallback;
    logic             segment_end;
    logic             last;
  } out_item_t;

  // entry write broadcast to the cells
  typedef struct packed {
    logic [5:0]       index;
    logic             en;
    logic             enable;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] key_len;
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] value_len;
  } entry_wr_t;

  // best match so far, handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] len;
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] value_len;
  } best_t;

  function automatic logic [WORK_W-1:0] low_mask(input logic [6:0] n);
    logic [WORK_W:0] one;
    one = (WORK_W+1)'(1);
    if (n >= 7'(WORK_W)) return '1;
    return WORK_W'((one << n) - one);
  endfunction

endpackage
`default_nettype wire

// File: rtl/gtde_cell.sv
// One table entry cell: holds an entry and passes the best match onward.
`default_nettype none
module gtde_cell
  import gtde_pkg::*;
#(
  parameter int INDEX        = 0,
  parameter int MAX_KEY_BITS = MAX_KEY_BITS_DEF,
  parameter int FILL_W       = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire entry_wr_t         wr,
  input  wire logic [WORK_W-1:0] window,
  input  wire logic [FILL_W-1:0] fill,
  input  wire best_t             best_in,
  output best_t                  best_out
);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [LEN_W-1:0] key_len;
  logic [VAL_W-1:0] value;
  logic [LEN_W-1:0] value_len;

  logic [6:0]        shift;
  logic [WORK_W-1:0] mask;
  logic              hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr.index == 6'(INDEX)) begin
      valid <= wr.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.index == 6'(INDEX)) begin
      key       <= wr.key;
      key_len   <= wr.key_len;
      value     <= wr.value;
      value_len <= wr.value_len;
    end
  end

  always_comb begin
    shift = 7'(fill) - 7'(key_len);
    mask  = low_mask(7'(key_len));
    hit   = valid && key_len >= LEN_W'(2) && 7'(key_len) <= 7'(fill)
            && 7'(key_len) <= 7'(MAX_KEY_BITS)
            && key_len > best_in.len
            && ((window >> shift) & mask) == (WORK_W'(key) & mask);
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      best_out <= '{found: 1'b1, len: key_len, value: value, value_len: value_len};
    end else begin
      best_out <= best_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/greedy_table_dna_encoder.sv
// A load item, or a data bit that emits nothing, leaves the input open for
// the next item. A group is loaded into the output register once the window
// has swept the whole cell chain and the output register is free; a segment
// flush emits its groups one after another, each after its own sweep and any
// wait of a held result. The input reopens in the cycle after the last group
// loads. Reset clears entry valid bits, window, fill and segment position;
// the entry contents stay undefined until written, with no clearing pass.
`default_nettype none
module greedy_table_dna_encoder
  import gtde_pkg::*;
#(
  parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
  parameter int MAX_KEY_BITS      = MAX_KEY_BITS_DEF,
  parameter int MAX_VALUE_SYMBOLS = MAX_VALUE_SYMBOLS_DEF,
  parameter int SEGMENT_LENGTH    = SEGMENT_LENGTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire in_item_t  item,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_item_t      result
);

  localparam int W     = MAX_KEY_BITS;
  localparam int FILL_W = $clog2(W + 1);
  localparam int SPW   = $clog2(SEGMENT_LENGTH + 1);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;

  logic [1:0]        state;
  logic [W-1:0]      window;
  logic [FILL_W-1:0] fill;
  logic [SPW-1:0]    seg_pos;
  logic              flush;
  logic [CNT_W-1:0]  cnt;

  logic              accept;
  entry_wr_t         wr;
  logic [LEN_W-1:0]  vl_sat;
  best_t             chain [TABLE_ENTRIES+1];
  best_t             best;

  logic [FILL_W-1:0] fill_inc;
  logic [SPW-1:0]    seg_inc;
  logic              boundary;

  logic [FILL_W-1:0] fill_next;
  logic [WORK_W-1:0] win32;
  logic [1:0]        pair_idx;
  out_item_t         res_next;

  logic              out_free;
  logic              load_res;
  logic              res_fallback;

  assign accept     = item_valid && !item_stall;
  assign item_stall = state != ST_IDLE;

  // Saturate value length, zero symbols above it, and broadcast the write.
  always_comb begin
    vl_sat = item.value_length;
    if (7'(item.value_length) > 7'(MAX_VALUE_SYMBOLS)) begin
      vl_sat = LEN_W'(MAX_VALUE_SYMBOLS);
    end
    wr.index     = item.entry_index;
    wr.en        = accept && item.mode == MODE_LOAD
                   && 11'(item.entry_index) < 11'(TABLE_ENTRIES);
    wr.enable    = item.entry_enable;
    wr.key       = item.key_bits;
    wr.key_len   = item.key_length;
    wr.value     = item.value_symbols & low_mask(7'({vl_sat, 1'b0}));
    wr.value_len = vl_sat;
  end

  assign win32    = WORK_W'(window);
  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    gtde_cell #(
      .INDEX        (i),
      .MAX_KEY_BITS (MAX_KEY_BITS),
      .FILL_W       (FILL_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (wr),
      .window   (win32),
      .fill     (fill),
      .best_in  (chain[i]),
      .best_out (chain[i+1])
    );
  end

  assign best = chain[TABLE_ENTRIES];

  // Data bit bookkeeping.
  assign fill_inc = fill + FILL_W'(1);
  assign seg_inc  = seg_pos + SPW'(1);
  assign boundary = item.stream_last || 32'(seg_inc) >= 32'(SEGMENT_LENGTH);

  // Resolve one group from the chain's tail and the window front.
  always_comb begin
    pair_idx  = 2'd0;
    res_next  = '0;
    if (best.found) begin
      fill_next              = fill - FILL_W'(best.len);
      res_next.symbols       = best.value;
      res_next.symbol_count  = best.value_len;
      res_next.used_fallback = 1'b0;
    end else begin
      if (fill >= FILL_W'(2)) begin
        pair_idx  = 2'((win32 >> (fill - FILL_W'(2))) & WORK_W'(3));
        fill_next = fill - FILL_W'(2);
      end else begin
        pair_idx  = {win32[0], 1'b0};
        fill_next = '0;
      end
      case (pair_idx)
        2'd0:    res_next.symbols = PAIR_GA;
        2'd1:    res_next.symbols = PAIR_GT;
        2'd2:    res_next.symbols = PAIR_CA;
        default: res_next.symbols = PAIR_CT;
      endcase
      res_next.symbol_count  = PAIR_COUNT;
      res_next.used_fallback = 1'b1;
    end
    res_next.segment_end = flush && fill_next == '0;
    res_next.last        = !flush || fill_next == '0;
  end

  // The output register is free once its item is taken or it holds nothing.
  assign out_free = !result_valid || !result_stall;
  assign load_res = state == ST_SEARCH && cnt == CNT_W'(TABLE_ENTRIES) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      window  <= '0;
      fill    <= '0;
      seg_pos <= '0;
      flush   <= 1'b0;
      cnt     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && item.mode == MODE_DATA) begin
            // shift the bit in; resolve when the window is full or at a boundary
            window  <= {window[W-2:0], item.data_bit};
            fill    <= fill_inc;
            seg_pos <= boundary ? '0 : seg_inc;
            flush   <= boundary;
            cnt     <= '0;
            if (boundary || 32'(fill_inc) >= 32'(W)) begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          // wait until the window has swept the whole chain, then hold
          // the group until the output register can take it
          if (cnt == CNT_W'(TABLE_ENTRIES)) begin
            if (out_free) begin
              fill   <= fill_next;
              window <= window & W'(low_mask(7'(fill_next)));
              cnt    <= '0;
              state  <= (flush && fill_next != '0) ? ST_SEARCH : ST_IDLE;
            end
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: load a resolved group, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result <= res_next;
    end
  end

  assign res_fallback = result_valid && result.used_fallback;

`include "assert_macros.svh"

  `GTDE_ASSERT(a_fallback_pair, res_fallback |-> result.symbol_count == PAIR_COUNT, "bad pair")
  `GTDE_ASSERT(a_seg_end_last, result_valid |-> !result.segment_end || result.last, "bad end")
  `GTDE_ASSERT(a_fill_bound, 32'(fill) <= 32'(W), "window fill beyond key width")
  `GTDE_ASSERT(a_more_follows, result_valid && !result.last |-> item_stall, "flush stopped")

endmodule
`default_nettype wire
